FILE: rtl/tmvp_pkg.sv
// ----------------------------------------------------------------------------
// tmvp_pkg
// Shared types and constants for the transposed matrix-vector product block.
// ----------------------------------------------------------------------------
`default_nettype none

package tmvp_pkg;

  localparam int TMVP_MAX_SIZE = 1024;
  localparam int TMVP_SIZE_W   = 11;
  localparam int TMVP_ELEM_W   = 16;
  localparam int TMVP_PROD_W   = 32;
  localparam int TMVP_ACC_W    = 48;
  localparam int TMVP_IDX_W    = 10;

  typedef struct packed {
    logic signed [TMVP_ELEM_W-1:0] matrix_element;
    logic signed [TMVP_ELEM_W-1:0] vector_element;
  } tmvp_in_t;

  typedef struct packed {
    logic        [TMVP_IDX_W-1:0] column_index;
    logic signed [TMVP_ACC_W-1:0] column_sum;
    logic                         last_column;
  } tmvp_out_t;

  // position of the current item inside the matrix
  typedef struct packed {
    logic first_row;
    logic last_row;
    logic last_col;
  } tmvp_pos_t;

endpackage

`default_nettype wire

FILE: rtl/tmvp_ram.sv
// ----------------------------------------------------------------------------
// tmvp_ram
// Column accumulator memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tmvp_ram #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 48
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [DATA_W-1:0]        wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: rtl/tmvp_seq.sv
// ----------------------------------------------------------------------------
// tmvp_seq
// Size register and row/column counters that walk the matrix.
// ----------------------------------------------------------------------------
`default_nettype none

module tmvp_seq #(
  parameter int MAX_SIZE = tmvp_pkg::TMVP_MAX_SIZE
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_valid,
  output      logic                                 cfg_ready,
  input  wire logic [tmvp_pkg::TMVP_SIZE_W-1:0]     cfg_data,
  input  wire logic                                 advance,
  output      logic [$clog2(MAX_SIZE)-1:0]          col,
  output      tmvp_pkg::tmvp_pos_t                  pos
);

  import tmvp_pkg::*;

  localparam int CW = $clog2(MAX_SIZE);
  localparam int SW = ($clog2(MAX_SIZE + 1) > TMVP_SIZE_W) ? $clog2(MAX_SIZE + 1)
                                                          : TMVP_SIZE_W;

  logic [CW-1:0] col_r, col_nxt;
  logic [CW-1:0] row_r, row_nxt;
  logic [CW-1:0] last_r, last_nxt;
  logic [SW-1:0] size_ext;
  logic          cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign size_ext  = SW'(cfg_data);

  // zero acts as one, oversize clamps to the memory depth
  always_comb begin
    if (size_ext == '0) begin
      last_nxt = '0;
    end else if (size_ext > SW'(MAX_SIZE)) begin
      last_nxt = CW'(MAX_SIZE - 1);
    end else begin
      last_nxt = CW'(size_ext - SW'(1));
    end
  end

  assign pos.first_row = (row_r == '0);
  assign pos.last_row  = (row_r == last_r);
  assign pos.last_col  = (col_r == last_r);
  assign col           = col_r;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_wr) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (advance) begin
      if (pos.last_col) begin
        col_nxt = '0;
        row_nxt = pos.last_row ? '0 : row_r + CW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      last_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (cfg_wr) begin
        last_r <= last_nxt;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tmvp_mac.sv
// ----------------------------------------------------------------------------
// tmvp_mac
// Multiply stage, read-modify-write of the column sum, and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tmvp_mac #(
  parameter int MAX_SIZE = tmvp_pkg::TMVP_MAX_SIZE
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output      logic                                in_ready,
  input  wire tmvp_pkg::tmvp_in_t                  in_data,
  output      logic                                out_valid,
  input  wire logic                                out_ready,
  output      tmvp_pkg::tmvp_out_t                 out_data,
  input  wire logic [$clog2(MAX_SIZE)-1:0]         col,
  input  wire tmvp_pkg::tmvp_pos_t                 pos,
  output      logic                                accept,
  output      logic                                ram_wr_en,
  output      logic [$clog2(MAX_SIZE)-1:0]         ram_wr_addr,
  output      logic [tmvp_pkg::TMVP_ACC_W-1:0]     ram_wr_data,
  input  wire logic [tmvp_pkg::TMVP_ACC_W-1:0]     ram_rd_data
);

  import tmvp_pkg::*;

  localparam int CW = $clog2(MAX_SIZE);
  localparam int XW = (CW > TMVP_IDX_W) ? CW : TMVP_IDX_W;

  logic                          a_valid_r, a_valid_nxt;
  logic [CW-1:0]                 a_col_r;
  tmvp_pos_t                     a_pos_r;
  logic signed [TMVP_PROD_W-1:0] a_prod_r;
  logic                          a_fwd_r;
  logic [TMVP_ACC_W-1:0]         wb_r;
  logic                          out_valid_r, out_valid_nxt;
  tmvp_out_t                     out_data_r;
  logic signed [TMVP_PROD_W-1:0] prod;
  logic                          a_fire;
  logic [TMVP_ACC_W-1:0]         base;
  logic [TMVP_ACC_W-1:0]         sum;
  logic [XW-1:0]                 col_ext;

  assign prod = in_data.matrix_element * in_data.vector_element;

  // only a last-row item needs room in the output register
  assign a_fire   = a_valid_r && (!a_pos_r.last_row || !out_valid_r || out_ready);
  assign in_ready = !a_valid_r || a_fire;
  assign accept   = in_valid && in_ready;

  // back-to-back transfers to one column: the ram read missed the write
  assign base = a_pos_r.first_row ? '0 : (a_fwd_r ? wb_r : ram_rd_data);
  assign sum  = base + {{(TMVP_ACC_W - TMVP_PROD_W){a_prod_r[TMVP_PROD_W-1]}}, a_prod_r};

  assign ram_wr_en   = a_fire;
  assign ram_wr_addr = a_col_r;
  assign ram_wr_data = sum;

  assign col_ext = XW'(a_col_r);

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (accept) begin
      a_valid_nxt = 1'b1;
    end else if (a_fire) begin
      a_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (a_fire && a_pos_r.last_row) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r   <= a_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_col_r  <= col;
      a_pos_r  <= pos;
      a_prod_r <= prod;
      a_fwd_r  <= a_fire && (a_col_r == col);
    end
    if (a_fire) begin
      wb_r <= sum;
    end
    if (a_fire && a_pos_r.last_row) begin
      out_data_r.column_index <= col_ext[TMVP_IDX_W-1:0];
      out_data_r.column_sum   <= sum;
      out_data_r.last_column  <= a_pos_r.last_col;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: rtl/transposed_matrix_vector_product.sv
// ----------------------------------------------------------------------------
// transposed_matrix_vector_product
// Streams a square Q8.8 matrix row by row and returns y = A^T x per column.
// ----------------------------------------------------------------------------
// Takes one matrix element per cycle in row-major order, each with the vector
// value of its row, and keeps a 48-bit running sum per column in a single
// MAX_SIZE-entry memory (one read, one write per cycle). Row 0 overwrites the
// sums, so no clearing pass is needed after reset. During the last row each
// transfer yields that column's finished Q32.16 sum: its product is registered
// first, then the sum is registered at the output, flagged on the final
// column; the rate is one item per cycle, set by the read-modify-write of the
// accumulator memory, and drops only while the output is stalled. Writing
// cfg_data sets the size (0 acts as 1, values above MAX_SIZE clamp) and
// restarts at row 0, column 0; write only when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module transposed_matrix_vector_product #(
  parameter int MAX_SIZE = tmvp_pkg::TMVP_MAX_SIZE
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output      logic                             in_ready,
  input  wire tmvp_pkg::tmvp_in_t               in_data,
  output      logic                             out_valid,
  input  wire logic                             out_ready,
  output      tmvp_pkg::tmvp_out_t              out_data,
  input  wire logic                             cfg_valid,
  output      logic                             cfg_ready,
  input  wire logic [tmvp_pkg::TMVP_SIZE_W-1:0] cfg_data
);

  import tmvp_pkg::*;

  localparam int CW = $clog2(MAX_SIZE);

  logic [CW-1:0]         col;
  tmvp_pos_t             pos;
  logic                  accept;
  logic                  ram_wr_en;
  logic [CW-1:0]         ram_wr_addr;
  logic [TMVP_ACC_W-1:0] ram_wr_data;
  logic [TMVP_ACC_W-1:0] ram_rd_data;

  tmvp_seq #(
    .MAX_SIZE (MAX_SIZE)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .advance   (accept),
    .col       (col),
    .pos       (pos)
  );

  tmvp_ram #(
    .DEPTH  (MAX_SIZE),
    .DATA_W (TMVP_ACC_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (ram_rd_data)
  );

  tmvp_mac #(
    .MAX_SIZE (MAX_SIZE)
  ) u_mac (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .col         (col),
    .pos         (pos),
    .accept      (accept),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_data (ram_rd_data)
  );

endmodule

`default_nettype wire
